>>> design/swdm_pkg.sv
package swdm_pkg;

    localparam int TIME_W   = 32;
    localparam int MODE_W   = 4;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 48;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int MIU_W    = 5;
    localparam int CHAT_W   = 12;

    localparam logic [1:0] REG_MODES_IN_USE    = 2'd0;
    localparam logic [1:0] REG_MIN_DWELL_LIMIT = 2'd1;
    localparam logic [1:0] REG_ADT_PERIOD      = 2'd2;
    localparam logic [1:0] REG_CHATTER_BOUND   = 2'd3;

    localparam logic [MIU_W-1:0]  MODES_IN_USE_RST    = 5'd16;
    localparam logic [TIME_W-1:0] MIN_DWELL_LIMIT_RST = 32'd0;
    localparam logic [TIME_W-1:0] ADT_PERIOD_RST      = 32'd1000;
    localparam logic [CHAT_W-1:0] CHATTER_BOUND_RST   = 12'd16;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic [MODE_W-1:0] new_mode;
    } swdm_in_t;

    typedef struct packed {
        logic [TIME_W-1:0]  last_dwell;
        logic [TIME_W-1:0]  min_dwell_seen;
        logic [TIME_W-1:0]  max_dwell_seen;
        logic [SUM_W-1:0]   dwell_total;
        logic [COUNT_W-1:0] intervals_seen;
        logic [SUM_W-1:0]   left_mode_time;
        logic [COUNT_W-1:0] entered_mode_visits;
        logic               dwell_ok;
        logic               adt_ok;
        logic               order_error;
    } swdm_out_t;

    typedef struct packed {
        logic go;
        logic first;
        logic err;
    } swdm_step_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
        return (a == '1) ? a : a + COUNT_W'(1);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0]  a,
                                                      input logic [TIME_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

endpackage

>>> design/swdm_adt.sv
module swdm_adt (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swdm_pkg::swdm_step_t                step,
    input  logic [swdm_pkg::TIME_W-1:0]         event_time,
    input  logic [swdm_pkg::TIME_W-1:0]         adt_period,
    input  logic [swdm_pkg::CHAT_W-1:0]         chatter_bound,
    output logic                                adt_broken
);
    import swdm_pkg::*;

    localparam int PROD_W = TIME_W + CHAT_W;

    logic [62:0]        itp_reg;
    logic [62:0]        gap_reg;
    logic               broken_reg;
    logic [62:0]        itp_next;
    logic [62:0]        gap_next;
    logic [TIME_W-1:0]  tau;
    logic signed [63:0] diff;
    logic               diff_pos;
    logic               far;
    logic [PROD_W-1:0]  lhs;
    logic [PROD_W-1:0]  prod;
    logic               cap_hit;
    logic               break_now;

    // The gap is the current index-times-period less the smallest key so far,
    // so the new key minus the smallest key is the gap plus tau less the time.
    assign tau      = (adt_period == '0) ? TIME_W'(1) : adt_period;
    assign itp_next = step.first ? itp_reg : itp_reg + 63'(tau);
    assign cap_hit  = itp_next[62];
    assign diff     = $signed({1'b0, gap_reg}) + $signed(64'(tau)) - $signed(64'(event_time));
    assign diff_pos = !diff[63] && (diff != '0);
    assign far      = |diff[62:40];
    assign lhs      = {diff[39:0], 4'b0000};
    assign prod     = PROD_W'(chatter_bound) * PROD_W'(tau);
    assign break_now = cap_hit || (!step.first && diff_pos && (far || (lhs > prod)));
    assign gap_next = (step.first || diff[63]) ? 63'(event_time) : gap_reg + 63'(tau);
    assign adt_broken = broken_reg || (!step.err && break_now);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            itp_reg    <= '0;
            gap_reg    <= '0;
            broken_reg <= 1'b0;
        end else if (step.go && !step.err && !broken_reg) begin
            itp_reg    <= itp_next;
            gap_reg    <= gap_next;
            broken_reg <= break_now;
        end
    end

endmodule

>>> design/swdm_tab.sv
module swdm_tab #(
    parameter int MAX_MODES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swdm_pkg::swdm_step_t                step,
    input  logic [swdm_pkg::MODE_W-1:0]         new_mode,
    input  logic [swdm_pkg::MODE_W-1:0]         prev_mode,
    input  logic [swdm_pkg::TIME_W-1:0]         dwell,
    input  logic [swdm_pkg::MIU_W-1:0]          modes_in_use,
    output logic [swdm_pkg::SUM_W-1:0]          left_time,
    output logic [swdm_pkg::COUNT_W-1:0]        entered_visits
);
    import swdm_pkg::*;

    localparam int TAB_DEPTH = (MAX_MODES < (1 << MODE_W)) ? MAX_MODES : (1 << MODE_W);
    localparam int IDX_W     = $clog2(TAB_DEPTH);
    localparam logic [MIU_W-1:0] MODE_CAP = MIU_W'(TAB_DEPTH);

    logic [COUNT_W-1:0] visits_reg [TAB_DEPTH];
    logic [SUM_W-1:0]   times_reg  [TAB_DEPTH];
    logic [MIU_W-1:0]   limit;
    logic               enter_ok;
    logic               leave_ok;
    logic [IDX_W-1:0]   enter_idx;
    logic [IDX_W-1:0]   leave_idx;
    logic               commit;

    assign limit     = (modes_in_use > MODE_CAP) ? MODE_CAP : modes_in_use;
    assign enter_ok  = MIU_W'(new_mode) < limit;
    assign leave_ok  = !step.first && (MIU_W'(prev_mode) < limit);
    assign enter_idx = new_mode[IDX_W-1:0];
    assign leave_idx = prev_mode[IDX_W-1:0];
    assign commit    = step.go && !step.err;

    assign entered_visits = enter_ok ? sat_inc(visits_reg[enter_idx]) : '0;
    assign left_time      = leave_ok ? sat_add_sum(times_reg[leave_idx], dwell) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAB_DEPTH; i++) begin
                visits_reg[i] <= '0;
                times_reg[i]  <= '0;
            end
        end else if (commit) begin
            if (enter_ok) begin
                visits_reg[enter_idx] <= entered_visits;
            end
            if (leave_ok) begin
                times_reg[leave_idx] <= left_time;
            end
        end
    end

endmodule

>>> design/switching_dwell_time_monitor.sv
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  swdm_in_t  (event_time, new_mode)
// m_        out        m_valid / m_ready  swdm_out_t (dwell statistics and flags)
// apb       in/out     psel/penable/pready  four registers at byte offsets 0, 4, 8, 12
//
// A word goes from the input register to the output register, which shows its result until
// it is taken; one word is taken per cycle while m_ready does not stall the output.
// The running state and the mode tables are updated in the single pass between the two.
// A stall on m_ready holds the result and lets one more word wait in the input register.
// Synchronous active-low reset clears both tables and all state but the data words.
module switching_dwell_time_monitor #(
    parameter int MAX_MODES = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  swdm_pkg::swdm_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output swdm_pkg::swdm_out_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swdm_pkg::APB_AW-1:0]     paddr,
    input  logic [swdm_pkg::APB_DW-1:0]     pwdata,
    output logic [swdm_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import swdm_pkg::*;

    localparam int TB = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam logic [TIME_W-1:0] TMASK = TIME_W'((64'd1 << TB) - 64'd1);

    logic [MIU_W-1:0]   modes_in_use_reg;
    logic [TIME_W-1:0]  min_dwell_limit_reg;
    logic [TIME_W-1:0]  adt_period_reg;
    logic [CHAT_W-1:0]  chatter_bound_reg;

    swdm_in_t           in_reg;
    logic               in_valid_reg;
    swdm_out_t          out_reg;
    logic               out_valid_reg;

    logic               started_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic [MODE_W-1:0]  prev_mode_reg;
    logic [TIME_W-1:0]  min_reg;
    logic [TIME_W-1:0]  max_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [TIME_W-1:0]  min_next;
    logic [TIME_W-1:0]  max_next;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] count_next;

    logic [TIME_W-1:0]  t;
    logic [TIME_W-1:0]  dwell;
    logic               err;
    logic               upd_stats;
    logic               advance;
    logic [1:0]         reg_idx;
    logic               cfg_write;
    swdm_step_t         step;
    swdm_out_t          result;
    logic [SUM_W-1:0]   left_time;
    logic [COUNT_W-1:0] entered_visits;
    logic               adt_broken;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modes_in_use_reg    <= MODES_IN_USE_RST;
            min_dwell_limit_reg <= MIN_DWELL_LIMIT_RST;
            adt_period_reg      <= ADT_PERIOD_RST;
            chatter_bound_reg   <= CHATTER_BOUND_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_MODES_IN_USE:    modes_in_use_reg    <= pwdata[MIU_W-1:0];
                REG_MIN_DWELL_LIMIT: min_dwell_limit_reg <= pwdata[TIME_W-1:0];
                REG_ADT_PERIOD:      adt_period_reg      <= pwdata[TIME_W-1:0];
                REG_CHATTER_BOUND:   chatter_bound_reg   <= pwdata[CHAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODES_IN_USE:    prdata = APB_DW'(modes_in_use_reg);
            REG_MIN_DWELL_LIMIT: prdata = APB_DW'(min_dwell_limit_reg);
            REG_ADT_PERIOD:      prdata = APB_DW'(adt_period_reg);
            REG_CHATTER_BOUND:   prdata = APB_DW'(chatter_bound_reg);
            default:             prdata = '0;
        endcase
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign t         = in_reg.event_time & TMASK;
    assign err       = started_reg && (t <= prev_time_reg);
    assign dwell     = t - prev_time_reg;
    assign upd_stats = started_reg && !err;

    assign step.go    = advance;
    assign step.first = !started_reg;
    assign step.err   = err;

    assign min_next   = (upd_stats && (dwell < min_reg)) ? dwell : min_reg;
    assign max_next   = (upd_stats && (dwell > max_reg)) ? dwell : max_reg;
    assign sum_next   = upd_stats ? sat_add_sum(sum_reg, dwell) : sum_reg;
    assign count_next = upd_stats ? sat_inc(count_reg) : count_reg;

    swdm_tab #(
        .MAX_MODES (MAX_MODES)
    ) u_tab (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .new_mode       (in_reg.new_mode),
        .prev_mode      (prev_mode_reg),
        .dwell          (dwell),
        .modes_in_use   (modes_in_use_reg),
        .left_time      (left_time),
        .entered_visits (entered_visits)
    );

    swdm_adt u_adt (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .event_time    (t),
        .adt_period    (adt_period_reg),
        .chatter_bound (chatter_bound_reg),
        .adt_broken    (adt_broken)
    );

    always_comb begin
        result.last_dwell          = upd_stats ? dwell : '0;
        result.min_dwell_seen      = min_next;
        result.max_dwell_seen      = max_next;
        result.dwell_total         = sum_next;
        result.intervals_seen      = count_next;
        result.left_mode_time      = err ? '0 : left_time;
        result.entered_mode_visits = err ? '0 : entered_visits;
        result.dwell_ok            = min_next >= min_dwell_limit_reg;
        result.adt_ok              = (count_next != '0) && !adt_broken;
        result.order_error         = err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            prev_time_reg <= '0;
            prev_mode_reg <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && !err) begin
                started_reg   <= 1'b1;
                prev_time_reg <= t;
                prev_mode_reg <= in_reg.new_mode;
                min_reg       <= min_next;
                max_reg       <= max_next;
                sum_reg       <= sum_next;
                count_reg     <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

endmodule

>>> design/swdm_check.sv
module swdm_check (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input swdm_pkg::swdm_out_t             m_data
);
    import swdm_pkg::*;

    // A stalled result word must hold still until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Leaving reset empties both registers, so nothing is shown and a word can be taken.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // A rejected event reports no dwell and no table values.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.order_error |->
            m_data.last_dwell == '0 && m_data.left_mode_time == '0
            && m_data.entered_mode_visits == '0)
        else $error("rejected event reported table values");

    // Once an interval exists neither the minimum nor the last dwell can exceed the maximum.
    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.intervals_seen != '0 |->
            m_data.min_dwell_seen <= m_data.max_dwell_seen
            && m_data.last_dwell <= m_data.max_dwell_seen)
        else $error("dwell statistics out of order");

    // Average-dwell compliance needs at least one interval.
    a_adt_needs_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.intervals_seen == '0 |-> !m_data.adt_ok)
        else $error("adt_ok raised before any interval");

endmodule

bind switching_dwell_time_monitor swdm_check u_swdm_check (.*);
